// ===== hw/rtl/pfsd_pkg.sv =====
// Shared types and constants of the page free-space directory.
// Used by every module of the block; depends on nothing.
package pfsd_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int PAGE_W    = 10;
  localparam int CNT_W     = 11;
  localparam int OFF_W     = 26;
  localparam int DCNT_W    = 4;

  localparam logic [15:0] RST_PAGE_BYTES     = 16'd4096;
  localparam logic [15:0] RST_PAGE_CAPACITY  = 16'd4064;
  localparam logic [7:0]  RST_SLOT_OVERHEAD  = 8'd8;
  localparam logic [15:0] RST_PAGES_PER_FILE = 16'd1024;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] REG_PAGE_BYTES     = 2'd0;
  localparam logic [1:0] REG_PAGE_CAPACITY  = 2'd1;
  localparam logic [1:0] REG_SLOT_OVERHEAD  = 2'd2;
  localparam logic [1:0] REG_PAGES_PER_FILE = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TOO_BIG  = 3'd1;
  localparam logic [2:0] ST_NO_ENTRY = 3'd2;
  localparam logic [2:0] ST_ALREADY  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [15:0] page_bytes;
    logic [15:0] page_capacity;
    logic [7:0]  slot_overhead;
    logic [15:0] pages_per_file;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [PAGE_W-1:0] idx;
    logic [15:0]       size;
    logic [15:0]       need;
    logic              too_big;
  } qentry_t;

endpackage

// ===== hw/rtl/pfsd_front.sv =====
// Front end: accepts commands, checks insert sizes and queues the transaction.
// Depends on pfsd_pkg.
module pfsd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  pfsd_pkg::cfg_t   cfg,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       cmd,
  input  logic [9:0]       page_index,
  input  logic [15:0]      rec_bytes,
  input  logic             pop,
  output logic             q_nonempty,
  output pfsd_pkg::qentry_t q_head
);
  import pfsd_pkg::*;

  qentry_t     q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push;
  logic [16:0] need;
  qentry_t     ent;

  assign busy       = (cnt_r == 2'd2);
  assign q_nonempty = (cnt_r != 2'd0);
  assign q_head     = q_r[rp_r];
  assign push       = start && !busy && (cmd != CMD_NOP);

  always_comb begin
    need        = {1'b0, rec_bytes} + {9'd0, cfg.slot_overhead};
    ent.cmd     = cmd;
    ent.idx     = page_index;
    ent.size    = rec_bytes;
    ent.need    = need[15:0];
    ent.too_big = (rec_bytes > cfg.page_bytes) || (need > {1'b0, cfg.page_capacity});
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= ent;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop && q_nonempty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop && q_nonempty};
    end
  end
endmodule

// ===== hw/rtl/pfsd_back.sv =====
// Back end: directory memories, free-page scan, file number divider and results.
// Depends on pfsd_pkg.
module pfsd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  pfsd_pkg::cfg_t    cfg,
  input  logic              q_nonempty,
  input  pfsd_pkg::qentry_t q_head,
  output logic              pop,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [9:0]        out_result_page,
  output logic [9:0]        out_file_id,
  output logic [25:0]       out_page_offset,
  output logic [15:0]       out_free_bytes,
  output logic              out_new_page
);
  import pfsd_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_SCAN, S_DIV, S_APPEND} state_t;

  logic [15:0]      free_mem [MAX_PAGES];
  logic [OFF_W-1:0] off_mem  [MAX_PAGES];
  logic [9:0]       file_mem [MAX_PAGES];

  logic [15:0] free_q;
  logic [OFF_W-1:0] off_q;
  logic [9:0]  file_q;
  logic        rd_zero_r, rd_fresh_r;

  logic [PAGE_W-1:0] rd_addr;
  logic              we_free, we_app;
  logic [PAGE_W-1:0] wa;
  logic [15:0]       wfree;
  logic [OFF_W-1:0]  woff;
  logic [9:0]        wfile;

  state_t state_r, state_nxt;
  qentry_t item_r, item_nxt;
  logic [PAGE_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic fresh_r, fresh_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic chk_v_r, chk_v_nxt;
  logic [PAGE_W-1:0] chk_a_r, chk_a_nxt;
  logic [15:0] cfree_r, cfree_nxt;
  logic [OFF_W-1:0] coff_r, coff_nxt;
  logic [9:0] cfile_r, cfile_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [PAGE_W-1:0] quo_r, quo_nxt, nps_r, nps_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic ov_r, ov_nxt, onp_r, onp_nxt;
  logic [2:0] ost_r, ost_nxt;
  logic [9:0] opg_r, opg_nxt, ofile_r, ofile_nxt;
  logic [25:0] ooff_r, ooff_nxt;
  logic [15:0] ofree_r, ofree_nxt;

  logic [15:0] rfree;
  logic [OFF_W-1:0] roff;
  logic [9:0] rfile;
  logic [CNT_W-1:0] np;
  logic [16:0] fsum, rem_sh;
  logic [15:0] div;
  logic idx_ok, issue;

  assign rfree = rd_fresh_r ? RST_PAGE_CAPACITY : free_q;
  assign roff  = rd_zero_r ? '0 : off_q;
  assign rfile = rd_zero_r ? '0 : file_q;
  assign np    = {1'b0, cur_r} + CNT_W'(1);
  assign div   = (cfg.pages_per_file == 16'd0) ? 16'd1 : cfg.pages_per_file;
  assign pop   = (state_r == S_IDLE) && q_nonempty;

  always_ff @(posedge clk) begin
    free_q <= free_mem[rd_addr];
    off_q  <= off_mem[rd_addr];
    file_q <= file_mem[rd_addr];
    if (we_free) free_mem[wa] <= wfree;
    if (we_app) begin
      off_mem[wa]  <= woff;
      file_mem[wa] <= wfile;
    end
  end

  always_comb begin
    state_nxt = state_r;  item_nxt = item_r;  cur_nxt = cur_r;  hi_nxt = hi_r;
    fresh_nxt = fresh_r;  scan_nxt = scan_r;  chk_v_nxt = 1'b0;  chk_a_nxt = chk_a_r;
    cfree_nxt = cfree_r;  coff_nxt = coff_r;  cfile_nxt = cfile_r;
    rem_nxt = rem_r;  quo_nxt = quo_r;  nps_nxt = nps_r;  dcnt_nxt = dcnt_r;
    ov_nxt = 1'b0;  ost_nxt = ST_OK;  opg_nxt = opg_r;  ofile_nxt = ofile_r;
    ooff_nxt = ooff_r;  ofree_nxt = ofree_r;  onp_nxt = 1'b0;
    rd_addr = cur_r;  we_free = 1'b0;  we_app = 1'b0;  wa = cur_r;
    wfree = '0;  woff = '0;  wfile = '0;
    idx_ok = ({1'b0, item_r.idx} < CNT_W'(MAX_PAGES)) && ({1'b0, item_r.idx} <= hi_r);
    fsum = {1'b0, rfree} + {1'b0, item_r.size};
    issue = (scan_r <= hi_r);
    rem_sh = {rem_r, nps_r[PAGE_W-1]};
    case (state_r)
      S_IDLE: begin
        rd_addr = (q_head.cmd == CMD_INSERT) ? cur_r : q_head.idx;
        if (q_nonempty) begin
          item_nxt  = q_head;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_IDLE;
        opg_nxt   = item_r.idx;
        ofile_nxt = rfile;
        ooff_nxt  = roff;
        ofree_nxt = rfree;
        case (item_r.cmd)
          CMD_INSERT: begin
            ov_nxt  = 1'b1;
            opg_nxt = cur_r;
            cfree_nxt = rfree;  coff_nxt = roff;  cfile_nxt = rfile;
            if (item_r.too_big) begin
              ost_nxt = ST_TOO_BIG;
            end else if (rfree >= item_r.need) begin
              we_free   = 1'b1;
              wfree     = rfree - item_r.need;
              ofree_nxt = wfree;
              if (cur_r == '0) fresh_nxt = 1'b0;
            end else begin
              ov_nxt    = 1'b0;
              scan_nxt  = '0;
              state_nxt = S_SCAN;
            end
          end
          CMD_DELETE: begin
            ov_nxt = 1'b1;
            if (!idx_ok) begin
              ost_nxt = ST_NO_ENTRY;
              ofile_nxt = '0;  ooff_nxt = '0;  ofree_nxt = '0;
            end else if (rfree == cfg.page_capacity) begin
              ost_nxt = ST_ALREADY;
            end else begin
              we_free = 1'b1;
              wa      = item_r.idx;
              wfree   = (fsum > {1'b0, cfg.page_capacity}) ? cfg.page_capacity : fsum[15:0];
              ofree_nxt = wfree;
              if (item_r.idx == '0) fresh_nxt = 1'b0;
            end
          end
          CMD_LOOKUP: begin
            ov_nxt = 1'b1;
            if (!idx_ok) begin
              ost_nxt = ST_NO_ENTRY;
              ofile_nxt = '0;  ooff_nxt = '0;  ofree_nxt = '0;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        rd_addr   = scan_r[PAGE_W-1:0];
        chk_v_nxt = issue;
        chk_a_nxt = scan_r[PAGE_W-1:0];
        scan_nxt  = scan_r + CNT_W'(1);
        if (chk_v_r && rfree == cfg.page_capacity) begin
          chk_v_nxt = 1'b0;
          we_free   = 1'b1;
          wa        = chk_a_r;
          wfree     = rfree - item_r.need;
          if (chk_a_r == '0) fresh_nxt = 1'b0;
          cur_nxt   = chk_a_r;
          ov_nxt    = 1'b1;
          opg_nxt   = chk_a_r;
          ofile_nxt = rfile;
          ooff_nxt  = roff;
          ofree_nxt = wfree;
          state_nxt = S_IDLE;
        end else if (!chk_v_r && !issue) begin
          if (np >= CNT_W'(MAX_PAGES)) begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_FULL;
            opg_nxt   = cur_r;
            ofile_nxt = cfile_r;
            ooff_nxt  = coff_r;
            ofree_nxt = cfree_r;
            state_nxt = S_IDLE;
          end else begin
            rem_nxt   = '0;
            quo_nxt   = '0;
            nps_nxt   = np[PAGE_W-1:0];
            dcnt_nxt  = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        nps_nxt  = {nps_r[PAGE_W-2:0], 1'b0};
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (rem_sh >= {1'b0, div}) begin
          rem_nxt = rem_sh[15:0] - div;
          quo_nxt = {quo_r[PAGE_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[15:0];
          quo_nxt = {quo_r[PAGE_W-2:0], 1'b0};
        end
        if (dcnt_r == DCNT_W'(PAGE_W - 1)) state_nxt = S_APPEND;
      end
      S_APPEND: begin
        we_free = 1'b1;
        we_app  = 1'b1;
        wa      = np[PAGE_W-1:0];
        wfree   = cfg.page_capacity - item_r.need;
        woff    = coff_r + {{(OFF_W - 16){1'b0}}, cfg.page_bytes};
        wfile   = quo_r;
        cur_nxt = np[PAGE_W-1:0];
        if (np > hi_r) hi_nxt = np;
        ov_nxt    = 1'b1;
        onp_nxt   = 1'b1;
        opg_nxt   = np[PAGE_W-1:0];
        ofile_nxt = wfile;
        ooff_nxt  = woff;
        ofree_nxt = wfree;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;  scan_r <= scan_nxt;  chk_a_r <= chk_a_nxt;
    cfree_r <= cfree_nxt;  coff_r <= coff_nxt;  cfile_r <= cfile_nxt;
    rem_r <= rem_nxt;  quo_r <= quo_nxt;  nps_r <= nps_nxt;  dcnt_r <= dcnt_nxt;
    ost_r <= ost_nxt;  opg_r <= opg_nxt;  ofile_r <= ofile_nxt;
    ooff_r <= ooff_nxt;  ofree_r <= ofree_nxt;  onp_r <= onp_nxt;
    rd_zero_r  <= (rd_addr == '0);
    rd_fresh_r <= (rd_addr == '0) && fresh_r;
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
      hi_r    <= '0;
      fresh_r <= 1'b1;
      chk_v_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      hi_r    <= hi_nxt;
      fresh_r <= fresh_nxt;
      chk_v_r <= chk_v_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_result_page = opg_r;
  assign out_file_id     = ofile_r;
  assign out_page_offset = ooff_r;
  assign out_free_bytes  = ofree_r;
  assign out_new_page    = onp_r;
endmodule

// ===== hw/rtl/page_free_space_directory.sv =====
// Top level of the page free-space directory: configuration registers,
// front end and back end. Depends on pfsd_pkg, pfsd_front and pfsd_back.
//
// A command (insert, delete, lookup) is taken on a clock edge with start high
// and busy low. A two-entry queue sits between the front end and the back end,
// so busy rises only when two transactions wait. Command code 3 is taken and
// dropped without a result.
// Each other command gives one result, shown for one cycle with out_valid high;
// the receiver cannot hold it off, so the output side never stalls.
// Lookup, delete and an insert that is too big or fits the current page go
// through the queue, one memory read and one evaluation from acceptance to result.
// The back end takes the next command only once it is through with the last one.
// An insert that does not fit scans the directory one entry a cycle through
// the memory read port for the first wholly free page. With no wholly free page
// among the pages in use the scan is followed by a bit-serial divider for the
// file number and then by the append of a new page.
// Configuration registers are written with cfg_we, cfg_index and cfg_wdata
// while the block is idle. Reset restores the default configuration and a
// directory holding page 0 only; no clearing pass is needed.
module page_free_space_directory (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [9:0]  in_page_index,
  input  logic [15:0] in_rec_bytes,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [9:0]  out_result_page,
  output logic [9:0]  out_file_id,
  output logic [25:0] out_page_offset,
  output logic [15:0] out_free_bytes,
  output logic        out_new_page,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import pfsd_pkg::*;

  cfg_t    cfg_r;
  logic    pop, q_nonempty;
  qentry_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.page_bytes     <= RST_PAGE_BYTES;
      cfg_r.page_capacity  <= RST_PAGE_CAPACITY;
      cfg_r.slot_overhead  <= RST_SLOT_OVERHEAD;
      cfg_r.pages_per_file <= RST_PAGES_PER_FILE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAGE_BYTES:     cfg_r.page_bytes     <= cfg_wdata;
        REG_PAGE_CAPACITY:  cfg_r.page_capacity  <= cfg_wdata;
        REG_SLOT_OVERHEAD:  cfg_r.slot_overhead  <= cfg_wdata[7:0];
        REG_PAGES_PER_FILE: cfg_r.pages_per_file <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pfsd_front u_front (
    .clk, .rst_n, .cfg(cfg_r), .start, .busy,
    .cmd(in_cmd), .page_index(in_page_index), .rec_bytes(in_rec_bytes),
    .pop, .q_nonempty, .q_head
  );

  pfsd_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_nonempty, .q_head, .pop,
    .out_valid, .out_status, .out_result_page, .out_file_id,
    .out_page_offset, .out_free_bytes, .out_new_page
  );
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the page free-space directory.
// Depends on pfsd_pkg and page_free_space_directory; holds its own predictor.
module testbench;
  import pfsd_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  page;
    logic [9:0]  file_id;
    logic [25:0] offset;
    logic [15:0] free_bytes;
    logic        new_page;
  } dir_result_t;

  class dir_scoreboard;
    bit [15:0] pg_bytes, pg_cap, per_file;
    bit [7:0]  overhead;
    bit [15:0] free_b[MAX_PAGES];
    bit        valid_b[MAX_PAGES];
    bit [25:0] off_b[MAX_PAGES];
    bit [9:0]  file_b[MAX_PAGES];
    bit [9:0]  cur_page;
    dir_result_t expected[$];
    int errors;
    int checked;
    int appends;
    int fulls;

    function new();
      pg_bytes = RST_PAGE_BYTES;
      pg_cap = RST_PAGE_CAPACITY;
      overhead = RST_SLOT_OVERHEAD;
      per_file = RST_PAGES_PER_FILE;
      valid_b[0] = 1'b1;
      free_b[0] = RST_PAGE_CAPACITY;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        REG_PAGE_BYTES: pg_bytes = v;
        REG_PAGE_CAPACITY: pg_cap = v;
        REG_SLOT_OVERHEAD: overhead = v[7:0];
        REG_PAGES_PER_FILE: per_file = v;
        default: ;
      endcase
    endfunction

    function dir_result_t entry(logic [2:0] st, int p, bit have, bit np);
      dir_result_t r;
      r.status = st;
      r.page = p[9:0];
      r.file_id = have ? file_b[p] : 10'd0;
      r.offset = have ? off_b[p] : 26'd0;
      r.free_bytes = have ? free_b[p] : 16'd0;
      r.new_page = np;
      return r;
    endfunction

    function void note(logic [1:0] cmd, logic [9:0] idx, logic [15:0] size);
      int unsigned need, f, np, dv;
      int hit;
      need = size + overhead;
      hit = -1;
      if (cmd == CMD_INSERT) begin
        if (size > pg_bytes || need > pg_cap) begin
          expected.push_back(entry(ST_TOO_BIG, cur_page, 1, 0));
        end else if (valid_b[cur_page] && free_b[cur_page] >= need) begin
          free_b[cur_page] = 16'(free_b[cur_page] - need);
          expected.push_back(entry(ST_OK, cur_page, 1, 0));
        end else begin
          for (int p = 0; p < MAX_PAGES && hit < 0; p++)
            if (valid_b[p] && free_b[p] == pg_cap) hit = p;
          if (hit >= 0) begin
            cur_page = 10'(hit);
            free_b[hit] = 16'(free_b[hit] - need);
            expected.push_back(entry(ST_OK, hit, 1, 0));
          end else if (cur_page + 1 >= MAX_PAGES) begin
            fulls++;
            expected.push_back(entry(ST_FULL, cur_page, 1, 0));
          end else begin
            np = cur_page + 1;
            dv = per_file ? per_file : 1;
            off_b[np] = off_b[cur_page] + pg_bytes;
            file_b[np] = 10'(np / dv);
            free_b[np] = 16'(pg_cap - need);
            valid_b[np] = 1'b1;
            cur_page = 10'(np);
            appends++;
            expected.push_back(entry(ST_OK, np, 1, 1));
          end
        end
      end else if (cmd == CMD_DELETE || cmd == CMD_LOOKUP) begin
        if (!valid_b[idx]) begin
          expected.push_back(entry(ST_NO_ENTRY, idx, 0, 0));
        end else if (cmd == CMD_LOOKUP) begin
          expected.push_back(entry(ST_OK, idx, 1, 0));
        end else if (free_b[idx] == pg_cap) begin
          expected.push_back(entry(ST_ALREADY, idx, 1, 0));
        end else begin
          f = free_b[idx] + size;
          if (f > pg_cap) f = pg_cap;
          free_b[idx] = 16'(f);
          expected.push_back(entry(ST_OK, idx, 1, 0));
        end
      end
    endfunction

    function void check(dir_result_t got);
      dir_result_t exp_r;
      checked++;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = expected.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: status %0d/%0d page %0d/%0d file %0d/%0d",
                    " off %0h/%0h free %0d/%0d new %0b/%0b"},
                   exp_r.status, got.status, exp_r.page, got.page, exp_r.file_id,
                   got.file_id, exp_r.offset, got.offset, exp_r.free_bytes,
                   got.free_bytes, exp_r.new_page, got.new_page);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = '0;
  logic [9:0]  in_page_index = '0;
  logic [15:0] in_rec_bytes = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [9:0]  out_result_page, out_file_id;
  logic [25:0] out_page_offset;
  logic [15:0] out_free_bytes;
  logic        out_new_page;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  dir_scoreboard sb = new();
  int sent = 0;
  int idle_pct = 13;

  page_free_space_directory dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check({out_status, out_result_page, out_file_id, out_page_offset,
                out_free_bytes, out_new_page});
  end

  task automatic send(logic [1:0] cmd, logic [9:0] idx, logic [15:0] size);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_page_index <= idx;
    in_rec_bytes <= size;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(cmd, idx, size);
    sent++;
    if (sent < 600) idle_pct = 13;
    else if (sent < 1200) idle_pct = 84;
    else idle_pct = 0;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] pb, logic [15:0] cap, logic [7:0] ov,
                           logic [15:0] ppf);
    logic [15:0] vals[4];
    vals = '{pb, cap, {8'd0, ov}, ppf};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(i[1:0], vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_items(int n);
    int r, top;
    logic [1:0]  cmd;
    logic [9:0]  idx;
    logic [15:0] size;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      cmd = r < 50 ? CMD_INSERT : r < 72 ? CMD_DELETE : r < 96 ? CMD_LOOKUP : CMD_NOP;
      top = sb.cur_page + 2 > 1023 ? 1023 : sb.cur_page + 2;
      idx = $urandom_range(9) < 8 ? 10'($urandom_range(top)) : 10'($urandom);
      if ($urandom_range(9) == 0) size = 16'($urandom);
      else size = 16'($urandom_range(sb.pg_cap / 3));
      send(cmd, idx, size);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(CMD_INSERT, 10'd0, 16'd0);
    send(CMD_INSERT, 10'd0, 16'd4088);
    send(CMD_INSERT, 10'd0, 16'd4097);
    send(CMD_INSERT, 10'd0, 16'd4056);
    send(CMD_INSERT, 10'd0, 16'hffff);
    send(CMD_LOOKUP, 10'd1, 16'd0);
    send(CMD_DELETE, 10'd0, 16'hffff);
    send(CMD_DELETE, 10'd0, 16'd5);
    send(CMD_DELETE, 10'd1023, 16'd5);
    send(CMD_LOOKUP, 10'd1023, 16'hffff);
    send(CMD_LOOKUP, 10'd5, 16'd0);
    send(CMD_NOP, 10'h3ff, 16'hffff);
    send(CMD_INSERT, 10'd0, 16'd100);
    send(CMD_DELETE, 10'd0, 16'd50);
    send(CMD_LOOKUP, 10'd0, 16'd0);
    send(CMD_DELETE, 10'd1, 16'd4064);
    random_items(190);
    configure(16'hffff, 16'hffff, 8'hff, 16'd1);
    random_items(200);
    configure(16'd1, 16'd1, 8'd0, 16'hffff);
    random_items(200);
    configure(16'd4096, 16'd200, 8'd8, 16'd3);
    random_items(200);
    configure(16'd40000, 16'd1, 8'd0, 16'd7);
    for (int k = 0; k < 1040; k++) begin
      if (k % 9 == 4) send(CMD_LOOKUP, 10'($urandom), 16'd0);
      else send(CMD_INSERT, 10'($urandom), 16'd1);
    end
    drain();
    $display("Ran %0d transactions over five register settings: %0d results checked,",
             sent, sb.checked);
    $display("%0d pages appended, %0d directory-full answers, %0d mismatches.",
             sb.appends, sb.fulls, sb.errors);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
